/* design/pcu_pkg.sv */
// ----------------------------------------------------------------------------
// pcu_pkg
// Shared types, register codes and helpers for the playfair pair cipher unit.
// ----------------------------------------------------------------------------
package pcu_pkg;

  // key square geometry
  localparam int SIDE       = 5;
  localparam int CELLS      = SIDE * SIDE;
  localparam int CELL_IDX_W = $clog2(CELLS);

  // configuration port geometry
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 4;

  typedef logic [7:0]             char_t;
  typedef logic [2:0]             coord_t;
  typedef logic [CELLS-1:0][7:0]  square_t;

  // one pair of letters on its way to the cipher stage
  typedef struct packed {
    char_t a;
    char_t b;
    logic  last;
  } pair_t;

  // head of the pair buffer as seen by the cipher stage
  typedef struct packed {
    logic  valid;
    pair_t pair;
  } pair_link_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_LO  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_MID = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_HI  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_LAST = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILLER    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 4'd7;

  // reset values of the letter registers
  localparam char_t RST_MISSING = 8'd74;
  localparam char_t RST_REPLACE = 8'd73;
  localparam char_t RST_FILLER  = 8'd88;

  // move one place along a row or column, wrapping at the edge
  function automatic coord_t wrap_step(coord_t c, logic back);
    coord_t res;
    if (back) begin
      res = (c == coord_t'(0)) ? coord_t'(SIDE - 1) : coord_t'(c - coord_t'(1));
    end else begin
      res = (c == coord_t'(SIDE - 1)) ? coord_t'(0) : coord_t'(c + coord_t'(1));
    end
    return res;
  endfunction

  // row-major cell index from row and column
  function automatic logic [CELL_IDX_W-1:0] cell_idx(coord_t r, coord_t c);
    return CELL_IDX_W'(int'(r) * SIDE + int'(c));
  endfunction

endpackage

/* design/pcu_pair_former.sv */
// ----------------------------------------------------------------------------
// pcu_pair_former
// Letter substitution, pair grouping with filler insertion, two-entry pair
// buffer feeding the cipher stage.
// ----------------------------------------------------------------------------
module pcu_pair_former (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcu_pkg::char_t     in_char,
  input  logic               in_end_of_message,
  input  pcu_pkg::char_t     missing_char,
  input  pcu_pkg::char_t     replacement_char,
  input  pcu_pkg::char_t     filler_char,
  input  logic               pop,
  output pcu_pkg::pair_link_t head
);
  import pcu_pkg::*;

  logic        accept;
  char_t       ch;
  pair_t       gen0;
  pair_t       gen1;
  logic [1:0]  n_gen;
  logic        pend_valid_r;
  logic        pend_valid_nxt;
  char_t       pend_char_r;
  char_t       pend_char_nxt;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  pair_t       slot_r   [2];
  pair_t       slot_nxt [2];

  // swap the missing letter for its replacement
  assign ch = (in_char == missing_char) ? replacement_char : in_char;

  // take a new letter only when the buffer is empty or its last pair drains this cycle
  assign in_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign accept   = in_valid && in_ready;

  // pairing rules
  always_comb begin
    gen0           = '{a: pend_char_r, b: ch, last: in_end_of_message};
    gen1           = '{a: ch, b: filler_char, last: 1'b1};
    n_gen          = 2'd0;
    pend_valid_nxt = pend_valid_r;
    pend_char_nxt  = pend_char_r;
    if (pend_valid_r) begin
      if (ch != pend_char_r) begin
        n_gen          = 2'd1;
        pend_valid_nxt = 1'b0;
      end else begin
        // doubled letter: close the held one with filler
        gen0 = '{a: pend_char_r, b: filler_char, last: 1'b0};
        if (in_end_of_message) begin
          n_gen          = 2'd2;
          pend_valid_nxt = 1'b0;
        end else begin
          n_gen          = 2'd1;
          pend_valid_nxt = 1'b1;
          pend_char_nxt  = ch;
        end
      end
    end else begin
      if (in_end_of_message) begin
        // lone final letter gets padded
        gen0           = '{a: ch, b: filler_char, last: 1'b1};
        n_gen          = 2'd1;
        pend_valid_nxt = 1'b0;
      end else begin
        pend_valid_nxt = 1'b1;
        pend_char_nxt  = ch;
      end
    end
  end

  // pair buffer update
  always_comb begin
    cnt_nxt     = cnt_r;
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    if (accept) begin
      slot_nxt[0] = gen0;
      slot_nxt[1] = gen1;
      cnt_nxt     = n_gen;
    end else if (pop) begin
      slot_nxt[0] = slot_r[1];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.pair  = slot_r[0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= 2'd0;
      pend_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        pend_valid_r <= pend_valid_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
    if (accept) begin
      pend_char_r <= pend_char_nxt;
    end
  end

endmodule

/* design/pcu_pair_xform.sv */
// ----------------------------------------------------------------------------
// pcu_pair_xform
// Square lookup and playfair row, column and rectangle rules for one pair,
// with the result register on the output channel.
// ----------------------------------------------------------------------------
module pcu_pair_xform (
  input  logic                clk,
  input  logic                rst_n,
  input  pcu_pkg::pair_link_t head,
  output logic                pop,
  input  pcu_pkg::square_t    cells,
  input  logic                decode_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output pcu_pkg::char_t      out_first_out,
  output pcu_pkg::char_t      out_second_out,
  output logic                out_not_in_square,
  output logic                out_last_pair
);
  import pcu_pkg::*;

  logic   hit_a;
  logic   hit_b;
  coord_t ra;
  coord_t ca;
  coord_t rb;
  coord_t cb;
  coord_t r1;
  coord_t c1;
  coord_t r2;
  coord_t c2;
  logic   err;
  char_t  first_c;
  char_t  second_c;

  logic   out_valid_r;
  char_t  first_r;
  char_t  second_r;
  logic   err_r;
  logic   last_r;

  // locate both letters, lowest cell wins
  always_comb begin
    hit_a = 1'b0;
    hit_b = 1'b0;
    ra    = '0;
    ca    = '0;
    rb    = '0;
    cb    = '0;
    for (int k = CELLS - 1; k >= 0; k--) begin
      if (cells[k] == head.pair.a) begin
        hit_a = 1'b1;
        ra    = coord_t'(k / SIDE);
        ca    = coord_t'(k % SIDE);
      end
      if (cells[k] == head.pair.b) begin
        hit_b = 1'b1;
        rb    = coord_t'(k / SIDE);
        cb    = coord_t'(k % SIDE);
      end
    end
  end

  // same row, same column or rectangle
  always_comb begin
    r1 = ra;
    c1 = ca;
    r2 = rb;
    c2 = cb;
    if (ra == rb) begin
      c1 = wrap_step(ca, decode_mode);
      c2 = wrap_step(cb, decode_mode);
    end else if (ca == cb) begin
      r1 = wrap_step(ra, decode_mode);
      r2 = wrap_step(rb, decode_mode);
    end else begin
      c1 = cb;
      c2 = ca;
    end
  end

  // error pairs read as zero
  assign err      = !hit_a || !hit_b || (head.pair.a == head.pair.b);
  assign first_c  = err ? '0 : cells[cell_idx(r1, c1)];
  assign second_c = err ? '0 : cells[cell_idx(r2, c2)];

  // move the head pair into the result register when it is free or its pair leaves
  assign pop = head.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      first_r  <= first_c;
      second_r <= second_c;
      err_r    <= err;
      last_r   <= head.pair.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_out     = first_r;
  assign out_second_out    = second_r;
  assign out_not_in_square = err_r;
  assign out_last_pair     = last_r;

endmodule

/* design/playfair_pair_cipher_unit.sv */
// ----------------------------------------------------------------------------
// playfair_pair_cipher_unit
// Playfair pair cipher over a configurable 5x5 key square.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the receiver takes pairs freely. A
// letter that closes a pair passes the pair buffer and then the result register
// before it is presented on the output. The square lookup (25 parallel
// comparators per letter) and the row, column and rectangle rules are
// combinational between the pair buffer and the result register. The output
// port moves one pair per cycle while the receiver is ready, so a doubled letter
// at the end of a message, which yields two pairs, holds the input until the
// second of them leaves the pair buffer. Configuration writes take effect at
// once and are expected only while the unit is idle.
// ----------------------------------------------------------------------------
module playfair_pair_cipher_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pcu_pkg::char_t                    in_char,
  input  logic                              in_end_of_message,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pcu_pkg::char_t                    out_first_out,
  output pcu_pkg::char_t                    out_second_out,
  output logic                              out_not_in_square,
  output logic                              out_last_pair,
  input  logic                              cfg_we,
  input  logic [pcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcu_pkg::CFG_W-1:0]         cfg_wdata
);
  import pcu_pkg::*;

  square_t    cells_r;
  char_t      missing_r;
  char_t      replace_r;
  char_t      filler_r;
  logic       mode_r;
  pair_link_t head;
  logic       pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r   <= '0;
      missing_r <= RST_MISSING;
      replace_r <= RST_REPLACE;
      filler_r  <= RST_FILLER;
      mode_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS_LO:  cells_r[7:0]   <= cfg_wdata;
        REG_CELLS_MID: cells_r[15:8]  <= cfg_wdata;
        REG_CELLS_HI:  cells_r[23:16] <= cfg_wdata;
        REG_CELL_LAST: cells_r[24]    <= cfg_wdata[7:0];
        REG_MISSING:   missing_r      <= cfg_wdata[7:0];
        REG_REPLACE:   replace_r      <= cfg_wdata[7:0];
        REG_FILLER:    filler_r       <= cfg_wdata[7:0];
        REG_MODE:      mode_r         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pair grouping and buffer
  pcu_pair_former u_former (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char           (in_char),
    .in_end_of_message (in_end_of_message),
    .missing_char      (missing_r),
    .replacement_char  (replace_r),
    .filler_char       (filler_r),
    .pop               (pop),
    .head              (head)
  );

  // cipher rules and result register
  pcu_pair_xform u_xform (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .cells             (cells_r),
    .decode_mode       (mode_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_out     (out_first_out),
    .out_second_out    (out_second_out),
    .out_not_in_square (out_not_in_square),
    .out_last_pair     (out_last_pair)
  );

`ifndef ASSERT_OFF
  // a flagged pair carries no letters
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_in_square |-> (out_first_out == '0) && (out_second_out == '0))
    else $error("error pair carries nonzero letters");

  // the last character of a message always leaves a pair behind
  a_eom_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> head.valid)
    else $error("end of message produced no pair");

  // input stalls only while pairs wait in the buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> head.valid)
    else $error("input stalled with empty pair buffer");

  // a pair leaving the buffer always lands in the result register
  a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid)
    else $error("popped pair not presented");
`endif

endmodule

/* tb/playfair_pair_cipher_unit_tb.sv */
// ----------------------------------------------------------------------------
// playfair_pair_cipher_unit_tb
// Self-checking bench for the playfair pair cipher unit.
// ----------------------------------------------------------------------------
// Characters go in over a valid/ready channel. A behavioral model of the pair
// grouping and of the square rules predicts every pair transfer, and each one
// is checked field by field in order. A short directed table walks the square
// rules, doubled letters, padding and the flagged cases. Random messages
// follow under several key squares, letter settings and both modes, with the
// sender and the receiver backing off at random.
// ----------------------------------------------------------------------------
module playfair_pair_cipher_unit_tb;
  import pcu_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int TIMEOUT       = 5_000_000;

  // rows of the directed table run before the first square is loaded
  localparam int AFTER_RESET_ROWS = 3;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

  // classic square with J left out, first letter in the top byte
  localparam logic [8*CELLS-1:0] STD_KEY = "ABCDEFGHIKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    char_t first;
    char_t second;
    logic  err;
    logic  last;
  } pair_result_t;

  typedef struct packed {
    char_t        ch;
    logic         eom;
    logic         typed;
    pair_result_t want;
  } stim_row_t;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  char_t                in_char           = '0;
  logic                 in_end_of_message = 1'b0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  char_t                out_first_out;
  char_t                out_second_out;
  logic                 out_not_in_square;
  logic                 out_last_pair;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_W-1:0]     cfg_wdata         = '0;

  // shadow of the configuration
  char_t key_sq[CELLS];
  char_t swap_from;
  char_t swap_to;
  char_t pad_char;
  logic  decoding;

  // shadow of the letter held between transfers
  logic  held_v;
  char_t held_c;

  char_t        stage_cells[CELLS];
  pair_result_t pending_pairs[$];
  stim_row_t    dir_rows[$];
  int           sender_gap_pct;
  int           sink_stall_pct;
  int           mismatches = 0;

  playfair_pair_cipher_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char           (in_char),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_out     (out_first_out),
    .out_second_out    (out_second_out),
    .out_not_in_square (out_not_in_square),
    .out_last_pair     (out_last_pair),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #TIMEOUT;
    $display("Simulation FAILED");
    $finish;
  end

  // lowest cell holding a letter, -1 if none
  function automatic int cell_of(char_t ch);
    for (int k = 0; k < CELLS; k++) begin
      if (key_sq[k] == ch) return k;
    end
    return -1;
  endfunction

  // square rules for one pair
  function automatic pair_result_t cipher_pair(char_t a, char_t b, logic last);
    int pa, pb, r1, c1, r2, c2, hop, t;
    pair_result_t res;
    pa       = cell_of(a);
    pb       = cell_of(b);
    res      = '0;
    res.last = last;
    if (pa < 0 || pb < 0 || a == b) begin
      res.err = 1'b1;
      return res;
    end
    r1  = pa / SIDE;
    c1  = pa % SIDE;
    r2  = pb / SIDE;
    c2  = pb % SIDE;
    hop = decoding ? SIDE - 1 : 1;
    if (r1 == r2) begin
      c1 = (c1 + hop) % SIDE;
      c2 = (c2 + hop) % SIDE;
    end else if (c1 == c2) begin
      r1 = (r1 + hop) % SIDE;
      r2 = (r2 + hop) % SIDE;
    end else begin
      t  = c1;
      c1 = c2;
      c2 = t;
    end
    res.first  = key_sq[r1 * SIDE + c1];
    res.second = key_sq[r2 * SIDE + c2];
    return res;
  endfunction

  // pair grouping for one accepted character
  function automatic void predict_char(char_t raw, logic eom);
    char_t ch;
    ch = (raw == swap_from) ? swap_to : raw;
    if (held_v && ch != held_c) begin
      pending_pairs.push_back(cipher_pair(held_c, ch, eom));
      held_v = 1'b0;
      held_c = '0;
    end else begin
      // doubled letter closes the held one with the pad
      if (held_v) begin
        pending_pairs.push_back(cipher_pair(held_c, pad_char, 1'b0));
        held_v = 1'b0;
        held_c = '0;
      end
      if (eom) begin
        pending_pairs.push_back(cipher_pair(ch, pad_char, 1'b1));
      end else begin
        held_v = 1'b1;
        held_c = ch;
      end
    end
  endfunction

  function automatic pair_result_t flagged(logic last);
    pair_result_t res;
    res      = '0;
    res.err  = 1'b1;
    res.last = last;
    return res;
  endfunction

  function automatic void add_row(char_t ch, logic eom, logic typed, pair_result_t want);
    stim_row_t row;
    row.ch    = ch;
    row.eom   = eom;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // mostly square letters, with doubles, pad, missing letter and raw bytes
  function automatic char_t pick_char(char_t prev);
    int n;
    n = $urandom_range(99);
    if (n < 20) return prev;
    if (n < 75) return key_sq[$urandom_range(CELLS - 1)];
    if (n < 83) return swap_from;
    if (n < 90) return pad_char;
    return char_t'($urandom_range(255));
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_char(char_t ch, logic eom);
    while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_char           <= ch;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(ch, eom);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    case (idx)
      REG_CELLS_LO, REG_CELLS_MID, REG_CELLS_HI: begin
        for (int k = 0; k < 8; k++) key_sq[int'(idx) * 8 + k] = data[8*k +: 8];
      end
      REG_CELL_LAST: key_sq[CELLS-1] = data[7:0];
      REG_MISSING:   swap_from = data[7:0];
      REG_REPLACE:   swap_to = data[7:0];
      REG_FILLER:    pad_char = data[7:0];
      REG_MODE:      decoding = data[0];
      default: ;
    endcase
  endtask

  // write every register, unused upper bits filled with noise
  task automatic load_config(char_t miss, char_t repl, char_t fill, logic dec, logic poke);
    logic [CFG_W-1:0] word;
    for (int w = 0; w < 3; w++) begin
      for (int k = 0; k < 8; k++) word[8*k +: 8] = stage_cells[w * 8 + k];
      write_reg(REG_CELLS_LO + CFG_IDX_W'(w), word);
    end
    word = {$urandom, $urandom};
    word[7:0] = stage_cells[CELLS-1];
    write_reg(REG_CELL_LAST, word);
    word = {$urandom, $urandom};
    word[7:0] = miss;
    write_reg(REG_MISSING, word);
    word = {$urandom, $urandom};
    word[7:0] = repl;
    write_reg(REG_REPLACE, word);
    word = {$urandom, $urandom};
    word[7:0] = fill;
    write_reg(REG_FILLER, word);
    word = {$urandom, $urandom};
    word[0] = dec;
    write_reg(REG_MODE, word);
    if (poke) write_reg(REG_UNUSED, '1);
    cfg_we <= 1'b0;
  endtask

  task automatic stage_std_key();
    for (int k = 0; k < CELLS; k++) stage_cells[k] = STD_KEY[8*(CELLS-1-k) +: 8];
  endtask

  // wait out every pending pair and the pipeline behind it
  task automatic wait_idle();
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // check each pair transfer against the oldest prediction
  always @(posedge clk) begin
    pair_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("pair transfer with nothing pending: %0h %0h", out_first_out, out_second_out);
        mismatches++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_first_out !== want.first) begin
          $error("first_out: expected %0h, got %0h", want.first, out_first_out);
          mismatches++;
        end
        if (out_second_out !== want.second) begin
          $error("second_out: expected %0h, got %0h", want.second, out_second_out);
          mismatches++;
        end
        if (out_not_in_square !== want.err) begin
          $error("not_in_square: expected %0b, got %0b", want.err, out_not_in_square);
          mismatches++;
        end
        if (out_last_pair !== want.last) begin
          $error("last_pair: expected %0b, got %0b", want.last, out_last_pair);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    char_t     prev;
    char_t     ch;
    logic      eom;

    for (int k = 0; k < CELLS; k++) key_sq[k] = '0;
    swap_from      = RST_MISSING;
    swap_to        = RST_REPLACE;
    pad_char       = RST_FILLER;
    decoding       = 1'b0;
    held_v         = 1'b0;
    held_c         = '0;
    sender_gap_pct = 11;
    sink_stall_pct = 70;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // after reset the square is all zero bytes
    add_row("A", 1'b0, 1'b0, '0);
    add_row("B", 1'b1, 1'b1, flagged(1'b1));
    add_row(8'h00, 1'b1, 1'b1, flagged(1'b1));
    // same row, with wrap
    add_row("A", 1'b0, 1'b0, '0);
    add_row("B", 1'b0, 1'b0, '0);
    add_row("E", 1'b0, 1'b0, '0);
    add_row("A", 1'b0, 1'b0, '0);
    // same column, with wrap
    add_row("A", 1'b0, 1'b0, '0);
    add_row("F", 1'b0, 1'b0, '0);
    add_row("V", 1'b0, 1'b0, '0);
    add_row("A", 1'b0, 1'b0, '0);
    // rectangle
    add_row("H", 1'b0, 1'b0, '0);
    add_row("Y", 1'b0, 1'b0, '0);
    // doubled letter in mid message
    add_row("L", 1'b0, 1'b0, '0);
    add_row("L", 1'b0, 1'b0, '0);
    add_row("M", 1'b0, 1'b0, '0);
    // missing letter swapped before lookup
    add_row("J", 1'b0, 1'b0, '0);
    add_row("K", 1'b0, 1'b0, '0);
    // letter outside the square
    add_row("a", 1'b0, 1'b0, '0);
    add_row("B", 1'b0, 1'b1, flagged(1'b0));
    // doubled letter at end of message
    add_row("P", 1'b0, 1'b0, '0);
    add_row("P", 1'b1, 1'b0, '0);
    // lone pad letter pads to an identical pair
    add_row("X", 1'b1, 1'b1, flagged(1'b1));
    // byte extremes
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, flagged(1'b1));

    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      if (i == AFTER_RESET_ROWS) begin
        in_valid <= 1'b0;
        wait_idle();
        stage_std_key();
        load_config("J", "I", "X", 1'b0, 1'b0);
      end
      send_char(row.ch, row.eom);
      if (row.typed) begin
        void'(pending_pairs.pop_back());
        pending_pairs.push_back(row.want);
      end
    end
    in_valid <= 1'b0;
    wait_idle();

    // random messages under a new setting per phase
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          stage_std_key();
          load_config("J", "I", "X", 1'b0, 1'b0);
        end
        1: begin
          stage_std_key();
          load_config("J", "I", "Q", 1'b1, 1'b0);
        end
        2: begin
          sender_gap_pct = 70;
          sink_stall_pct = 11;
          for (int k = 0; k < CELLS; k++) stage_cells[k] = char_t'($urandom_range(255));
          load_config(char_t'($urandom_range(255)), char_t'($urandom_range(255)),
                      char_t'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        end
        3: begin
          for (int k = 0; k < CELLS; k++) stage_cells[k] = char_t'($urandom_range(255));
          stage_cells[0]       = 8'h00;
          stage_cells[7]       = 8'hFF;
          stage_cells[CELLS-1] = 8'hFF;
          load_config(8'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
        end
        4: begin
          sender_gap_pct = 0;
          sink_stall_pct = 0;
          // few distinct letters, so most appear in several cells
          for (int k = 0; k < CELLS; k++) stage_cells[k] = char_t'(8'h41 + $urandom_range(9));
          load_config(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b1);
        end
        default: begin
          stage_std_key();
          load_config("Q", "K", "Z", 1'b0, 1'b0);
        end
      endcase
      prev = key_sq[0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch  = pick_char(prev);
        eom = (n == PHASE_ITEMS - 1) || ($urandom_range(9) == 0);
        send_char(ch, eom);
        prev = ch;
      end
      in_valid <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pcu_pkg.sv
design/pcu_pair_former.sv
design/pcu_pair_xform.sv
design/playfair_pair_cipher_unit.sv
tb/playfair_pair_cipher_unit_tb.sv
